// ----- rtl/swmp_pkg.sv -----
// ----------------------------------------------------------------------------
// swmp_pkg
// Shared widths, reset values and types of the sliding window min/peak filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swmp_pkg;

	localparam int PIX_W = 8;
	localparam int WS_W  = 6;

	localparam logic [WS_W-1:0] WS_RESET = 6'd11;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [WS_W-1:0]  win_size_t;

	// emit: word yields a result; clr: word clears the peak first
	typedef struct packed {
		logic emit;
		logic clr;
	} ctl_t;

endpackage

`default_nettype wire

// ----- rtl/swmp_if.sv -----
// ----------------------------------------------------------------------------
// swmp_in_if / swmp_out_if
// Valid/ready channels for pixel words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmp_in_if;
	logic            valid;
	logic            ready;
	swmp_pkg::pixel_t pixel;
	logic            row_start;
	logic            clear_peak;

	modport source (output valid, output pixel, output row_start, output clear_peak,
		input ready);
	modport sink (input valid, input pixel, input row_start, input clear_peak,
		output ready);
endinterface

interface swmp_out_if;
	logic             valid;
	logic             ready;
	swmp_pkg::pixel_t min_value;
	swmp_pkg::pixel_t peak_value;

	modport source (output valid, output min_value, output peak_value, input ready);
	modport sink (input valid, input min_value, input peak_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/sliding_window_min_peak.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_peak
// Row-wise sliding window minimum of 8-bit pixels with a running peak.
// ----------------------------------------------------------------------------
//  channel       dir  payload                          handshake
//  pixels        in   pixel, row_start, clear_peak     valid/ready
//  results       out  min_value, peak_value            valid/ready
//  window_size   in   window_size_wdata (6 bits)       window_size_we
//
//  One pixel word is taken per cycle unless a stalled result backs up the pipe.
//  The pipe is the tap register, one register per level of the minimum tree,
//  then the peak/output register. Reset clears fill count, peak and all valids;
//  window_size resets to 11. Every stage holds while its successor is full, so
//  a stalled result backs up the pipe one stage at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_peak #(
	parameter int MAX_WINDOW = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   window_size_we,
	input  wire swmp_pkg::win_size_t    window_size_wdata,
	swmp_in_if.sink                     pixels,
	swmp_out_if.source                  results
);

	localparam int W  = swmp_pkg::PIX_W;
	localparam int L  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int P  = 1 << L;
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (FW > swmp_pkg::WS_W) ? FW : swmp_pkg::WS_W;

	swmp_pkg::win_size_t  window_size_q;
	logic [CW-1:0]        ws_ext;
	logic [CW-1:0]        win_eff;
	logic [(2*P-1)*W-1:0] tree_bus;
	logic [L:0]           lvl_valid;
	logic [L:0]           lvl_ready;
	swmp_pkg::ctl_t       lvl_ctl [L+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swmp_pkg::WS_RESET;
		end else if (window_size_we) begin
			window_size_q <= window_size_wdata;
		end
	end

	assign ws_ext  = CW'(window_size_q);
	assign win_eff = (window_size_q == '0) ? CW'(1) :
		(ws_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : ws_ext;

	swmp_window #(
		.MAX_WINDOW (MAX_WINDOW),
		.P          (P),
		.CW         (CW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.win_size  (win_eff),
		.out_valid (lvl_valid[0]),
		.out_ready (lvl_ready[0]),
		.out_ctl   (lvl_ctl[0]),
		.out_data  (tree_bus[P*W-1:0])
	);

	genvar i;
	generate
		for (i = 0; i < L; i++) begin : g_lvl
			localparam int N    = P >> i;
			localparam int OFS  = (2*P - 2*N) * W;
			localparam int OFS2 = (2*P - N) * W;
			swmp_min_stage #(
				.N (N)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (lvl_valid[i]),
				.in_ready  (lvl_ready[i]),
				.in_ctl    (lvl_ctl[i]),
				.in_data   (tree_bus[OFS +: N*W]),
				.out_valid (lvl_valid[i+1]),
				.out_ready (lvl_ready[i+1]),
				.out_ctl   (lvl_ctl[i+1]),
				.out_data  (tree_bus[OFS2 +: (N/2)*W])
			);
		end
	endgenerate

	swmp_peak u_peak (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lvl_valid[L]),
		.in_ready (lvl_ready[L]),
		.in_ctl   (lvl_ctl[L]),
		.in_min   (tree_bus[(2*P-2)*W +: W]),
		.results  (results)
	);

endmodule

`default_nettype wire

// ----- rtl/swmp_window.sv -----
// ----------------------------------------------------------------------------
// swmp_window
// Pixel shift line, row fill count and masked tap register feeding the tree.
// ----------------------------------------------------------------------------
`default_nettype none

module swmp_window #(
	parameter int MAX_WINDOW = 32,
	parameter int P          = 32,
	parameter int CW         = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	swmp_in_if.sink                          pixels,
	input  wire logic [CW-1:0]               win_size,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output swmp_pkg::ctl_t                   out_ctl,
	output logic [P*swmp_pkg::PIX_W-1:0]     out_data
);

	swmp_pkg::pixel_t win_q [MAX_WINDOW];
	swmp_pkg::pixel_t taps  [MAX_WINDOW];
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    fill_base;
	logic [CW-1:0]    fill_next;
	logic             emit;
	logic             fire;
	logic             valid_s1;
	swmp_pkg::ctl_t   ctl_s1;
	logic [P*swmp_pkg::PIX_W-1:0] data_s1;
	logic [P*swmp_pkg::PIX_W-1:0] data_d;

	assign pixels.ready = !valid_s1 || out_ready;
	assign fire         = pixels.valid && pixels.ready;

	assign fill_base = pixels.row_start ? '0 : fill_q;
	assign fill_next = (fill_base == CW'(MAX_WINDOW)) ? fill_base : fill_base + CW'(1);
	assign emit      = (fill_next >= win_size);

	always_comb begin
		taps[0] = pixels.pixel;
		for (int k = 1; k < MAX_WINDOW; k++) begin
			taps[k] = win_q[k-1];
		end
	end

	genvar g;
	generate
		for (g = 0; g < P; g++) begin : g_tap
			if (g < MAX_WINDOW) begin : g_live
				assign data_d[g*swmp_pkg::PIX_W +: swmp_pkg::PIX_W] =
					(CW'(g) < win_size) ? taps[g] : swmp_pkg::PIX_MAX;
			end else begin : g_pad
				assign data_d[g*swmp_pkg::PIX_W +: swmp_pkg::PIX_W] = swmp_pkg::PIX_MAX;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (fire) begin
				fill_q <= fill_next;
			end
			if (pixels.ready) begin
				valid_s1 <= fire && (emit || pixels.clear_peak);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				win_q[k] <= taps[k];
			end
			data_s1     <= data_d;
			ctl_s1.emit <= emit;
			ctl_s1.clr  <= pixels.clear_peak;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctl   = ctl_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

// ----- rtl/swmp_min_stage.sv -----
// ----------------------------------------------------------------------------
// swmp_min_stage
// One registered level of the minimum tree: pairs of N inputs reduce to N/2.
// ----------------------------------------------------------------------------
`default_nettype none

module swmp_min_stage #(
	parameter int N = 2
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire swmp_pkg::ctl_t                    in_ctl,
	input  wire logic [N*swmp_pkg::PIX_W-1:0]      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output swmp_pkg::ctl_t                         out_ctl,
	output logic [(N/2)*swmp_pkg::PIX_W-1:0]       out_data
);

	localparam int W = swmp_pkg::PIX_W;

	logic                        valid_q;
	swmp_pkg::ctl_t              ctl_q;
	logic [(N/2)*W-1:0]          data_q;
	logic [(N/2)*W-1:0]          data_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		for (int j = 0; j < N/2; j++) begin
			data_d[j*W +: W] = (in_data[2*j*W +: W] < in_data[(2*j+1)*W +: W]) ?
				in_data[2*j*W +: W] : in_data[(2*j+1)*W +: W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_q  <= in_ctl;
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

// ----- rtl/swmp_peak.sv -----
// ----------------------------------------------------------------------------
// swmp_peak
// Running peak of emitted minima and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmp_peak (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire swmp_pkg::ctl_t   in_ctl,
	input  wire swmp_pkg::pixel_t in_min,
	swmp_out_if.source            results
);

	swmp_pkg::pixel_t peak_q;
	swmp_pkg::pixel_t peak_base;
	swmp_pkg::pixel_t peak_new;
	logic             valid_q;
	swmp_pkg::pixel_t min_q;
	swmp_pkg::pixel_t peak_out_q;
	logic             take;

	assign in_ready  = !valid_q || results.ready;
	assign take      = in_valid && in_ready;
	assign peak_base = in_ctl.clr ? '0 : peak_q;
	assign peak_new  = (in_min > peak_base) ? in_min : peak_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				peak_q <= in_ctl.emit ? peak_new : peak_base;
			end
			if (in_ready) begin
				valid_q <= take && in_ctl.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_ctl.emit) begin
			min_q      <= in_min;
			peak_out_q <= peak_new;
		end
	end

	assign results.valid      = valid_q;
	assign results.min_value  = min_q;
	assign results.peak_value = peak_out_q;

endmodule

`default_nettype wire
